>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int VALUE_W    = 32;
	localparam int PRIO_W     = 8;
	localparam int OCC_W      = 5;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	typedef enum logic [1:0] {
		OP_INSERT          = 2'd0,
		OP_REMOVE_FIRST    = 2'd1,
		OP_REMOVE_EXACT    = 2'd2,
		OP_REMOVE_AT_LEAST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         key;
	} cmd_t;

endpackage

>>> hdl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic signed [VALUE_W-1:0] value;
	logic [PRIO_W-1:0]         priority_req;

	modport source (output valid, output kind, output value, output priority_req, input ready);
	modport sink (input valid, input kind, input value, input priority_req, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic signed [VALUE_W-1:0] removed_value;
	logic [PRIO_W-1:0]         removed_priority;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, output status, output removed_value,
		output removed_priority, output occupancy, input ready);
	modport sink (input valid, input status, input removed_value,
		input removed_priority, input occupancy, output ready);
endinterface

>>> hdl/spq_front.sv
// Front end: accepts request transactions, decodes the operation and clamps insert priority.
module spq_front #(
	parameter int PRIORITY_LEVELS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	output logic          cmd_valid,
	output spq_pkg::cmd_t cmd,
	input  logic          cmd_ready
);
	import spq_pkg::*;

	localparam logic [PRIO_W:0]   LEVELS   = (PRIO_W+1)'(PRIORITY_LEVELS);
	localparam logic [PRIO_W-1:0] TOP_PRIO = PRIO_W'(PRIORITY_LEVELS - 1);

	logic              cmd_valid_q;
	cmd_t              cmd_q;
	cmd_t              cmd_d;
	logic              take;
	logic [PRIO_W:0]   prio_wide;

	assign req.ready = !cmd_valid_q || cmd_ready;
	assign take      = req.valid && req.ready;
	assign prio_wide = {1'b0, req.priority_req};

	always_comb begin
		cmd_d.op    = op_t'(req.kind);
		cmd_d.value = req.value;
		cmd_d.key   = req.priority_req;
		if (cmd_d.op == OP_INSERT && prio_wide >= LEVELS) begin
			cmd_d.key = TOP_PRIO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (take) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;
endmodule

>>> hdl/spq_cmdq.sv
// Short command queue between the front end and the sorted store.
module spq_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  spq_pkg::cmd_t in_cmd,
	output logic          in_ready,
	output logic          out_valid,
	output spq_pkg::cmd_t out_cmd,
	input  logic          out_ready
);
	import spq_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CMDQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CMDQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end
endmodule

>>> hdl/spq_back.sv
// Back end: sorted register array, compare stage, shift stage and response register.
module spq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  spq_pkg::cmd_t cmd,
	output logic          cmd_ready,
	spq_rsp_if.source     rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic signed [VALUE_W-1:0] val_q [QUEUE_DEPTH];
	logic [PRIO_W-1:0]         pri_q [QUEUE_DEPTH];
	logic [CW-1:0]             count_q;

	logic                      valid_s1;
	cmd_t                      cmd_s1;
	logic [QUEUE_DEPTH-1:0]    keep_s1;
	logic [QUEUE_DEPTH-1:0]    keep_d;

	logic                      rsp_valid_q;
	status_t                   status_q;
	logic signed [VALUE_W-1:0] rval_q;
	logic [PRIO_W-1:0]         rpri_q;
	logic [OCC_W-1:0]          occ_q;

	logic                      take;
	logic                      fire;
	logic [QUEUE_DEPTH-1:0]    sel;
	logic                      found;
	logic signed [VALUE_W-1:0] hit_val;
	logic [PRIO_W-1:0]         hit_pri;
	status_t                   status_d;
	logic                      do_insert;
	logic                      do_remove;
	logic [CW-1:0]             count_d;
	logic [31:0]               occ_wide;

	assign cmd_ready = !valid_s1;
	assign take      = cmd_valid && cmd_ready;
	assign fire      = valid_s1 && (!rsp_valid_q || rsp.ready);

	// Compare every valid entry against the key: keep marks entries left in place.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			keep_d[i] = 1'b0;
			if (CW'(i) < count_q) begin
				case (cmd.op)
					OP_INSERT:          keep_d[i] = pri_q[i] <= cmd.key;
					OP_REMOVE_FIRST:    keep_d[i] = 1'b0;
					OP_REMOVE_EXACT:    keep_d[i] = pri_q[i] < cmd.key;
					OP_REMOVE_AT_LEAST: keep_d[i] = pri_q[i] < cmd.key;
					default:            keep_d[i] = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= cmd;
			keep_s1 <= keep_d;
		end
	end

	// Pick the first valid entry that is not kept.
	always_comb begin
		hit_val = '0;
		hit_pri = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel[i] = (CW'(i) < count_q) && !keep_s1[i] && (i == 0 || keep_s1[(i == 0) ? 0 : i-1]);
			if (sel[i]) begin
				hit_val = hit_val | val_q[i];
				hit_pri = hit_pri | pri_q[i];
			end
		end
		found = |sel;
	end

	always_comb begin
		status_d = ST_OK;
		if (cmd_s1.op == OP_INSERT) begin
			if (count_q == CW'(QUEUE_DEPTH)) begin
				status_d = ST_FULL;
			end
		end else if (count_q == '0) begin
			status_d = ST_EMPTY;
		end else if (!found) begin
			status_d = ST_NOMATCH;
		end else if (cmd_s1.op == OP_REMOVE_EXACT && hit_pri != cmd_s1.key) begin
			status_d = ST_NOMATCH;
		end
		do_insert = fire && cmd_s1.op == OP_INSERT && status_d == ST_OK;
		do_remove = fire && cmd_s1.op != OP_INSERT && status_d == ST_OK;
		count_d   = count_q;
		if (do_insert) begin
			count_d = count_q + CW'(1);
		end else if (do_remove) begin
			count_d = count_q - CW'(1);
		end
		occ_wide = 32'(count_d);
	end

	// Shift the store open for an insert, or closed over a removed entry.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (do_insert && !keep_s1[i]) begin
				if (i == 0 || keep_s1[(i == 0) ? 0 : i-1]) begin
					val_q[i] <= cmd_s1.value;
					pri_q[i] <= cmd_s1.key;
				end else begin
					val_q[i] <= val_q[(i == 0) ? 0 : i-1];
					pri_q[i] <= pri_q[(i == 0) ? 0 : i-1];
				end
			end else if (do_remove && !keep_s1[i] && i < QUEUE_DEPTH - 1) begin
				val_q[i] <= val_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
				pri_q[i] <= pri_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			occ_q    <= occ_wide[OCC_W-1:0];
			if (do_remove) begin
				rval_q <= hit_val;
				rpri_q <= hit_pri;
			end else begin
				rval_q <= '0;
				rpri_q <= '0;
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.removed_value    = rval_q;
	assign rsp.removed_priority = rpri_q;
	assign rsp.occupancy        = occ_q;
endmodule

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// Holds up to QUEUE_DEPTH entries in a register array kept sorted by ascending
// priority, oldest first among equal priorities. Each request transaction is one
// operation (insert, remove first, remove exact priority, remove priority at
// least) and yields exactly one response transaction with status and occupancy.
// A request passes through the decode register and then the command queue;
// while it is at the head of the queue all valid entries are compared against
// its key, and the compare result is registered with the command. The array is
// then shifted and the response register loaded. The back end takes no new
// operation until the previous one has shifted the array, since the
// compare-then-shift loop works on the single sorted array. Insert priorities
// at or above PRIORITY_LEVELS are clamped to PRIORITY_LEVELS-1.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH     = 16,
	parameter int PRIORITY_LEVELS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	logic front_valid;
	cmd_t front_cmd;
	logic front_ready;
	logic back_valid;
	cmd_t back_cmd;
	logic back_ready;

	spq_front #(
		.PRIORITY_LEVELS(PRIORITY_LEVELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd_valid(front_valid),
		.cmd      (front_cmd),
		.cmd_ready(front_ready)
	);

	spq_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_cmd   (front_cmd),
		.in_ready (front_ready),
		.out_valid(back_valid),
		.out_cmd  (back_cmd),
		.out_ready(back_ready)
	);

	spq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(back_valid),
		.cmd      (back_cmd),
		.cmd_ready(back_ready),
		.rsp      (rsp)
	);

	localparam logic [31:0] DEPTH_W = 32'(QUEUE_DEPTH);

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == DEPTH_W[OCC_W-1:0])
		else $error("full response without full occupancy");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty response with nonzero occupancy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.removed_value == '0 && rsp.removed_priority == '0)
		else $error("failed operation returned data");
endmodule
